### hdl/lrs_pkg.sv
package lrs_pkg;

  // Fixed widths of the row and configuration fields
  localparam int unsigned ROW_BITS = 64;
  localparam int unsigned LEN_BITS = 7;

  // Row length after reset: every column in use
  localparam logic [LEN_BITS-1:0] ROW_LEN_RESET = 7'd64;

  // Number of rows of the current grid kept in the window
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONE  = 2'd1,
    HELD_TWO  = 2'd2
  } held_e;

  // One result transaction
  typedef struct packed {
    logic [ROW_BITS-1:0] next_row;
    logic                frame_end;
  } res_t;

  // Which of the two computed rows enter the output queue this cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

### hdl/lrs_row_if.sv
interface lrs_row_if;
  logic                         valid;
  logic                         ready;
  logic [lrs_pkg::ROW_BITS-1:0] row_cells;
  logic                         last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

### hdl/lrs_res_if.sv
interface lrs_res_if;
  logic                         valid;
  logic                         ready;
  logic [lrs_pkg::ROW_BITS-1:0] next_row;
  logic                         frame_end;

  modport source (output valid, output next_row, output frame_end, input ready);
  modport sink (input valid, input next_row, input frame_end, output ready);
endinterface

### hdl/lrs_cfg_if.sv
interface lrs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lrs_pkg::LEN_BITS-1:0] row_length;

  modport source (output valid, output row_length, input ready);
  modport sink (input valid, input row_length, output ready);
endinterface

### hdl/lrs_cell.sv
module lrs_cell (
  input  logic [2:0] above_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] below_i,
  output logic       alive_o
);
  logic [3:0] nbr_count;

  // Count the eight neighbours around the centre cell
  always_comb begin
    nbr_count = 4'({3'b000, above_i[0]}) + 4'({3'b000, above_i[1]})
              + 4'({3'b000, above_i[2]}) + 4'({3'b000, mid_i[0]})
              + 4'({3'b000, mid_i[2]})   + 4'({3'b000, below_i[0]})
              + 4'({3'b000, below_i[1]}) + 4'({3'b000, below_i[2]});
  end

  // Birth on three, survival on two or three
  assign alive_o = (nbr_count == 4'd3) || ((nbr_count == 4'd2) && mid_i[1]);

endmodule

### hdl/lrs_row_lanes.sv
module lrs_row_lanes #(
  parameter int unsigned CELLS = 64
) (
  input  logic [CELLS-1:0] above_i,
  input  logic [CELLS-1:0] mid_i,
  input  logic [CELLS-1:0] below_i,
  input  logic [CELLS-1:0] mask_i,
  output logic [CELLS-1:0] next_row_o
);
  logic [CELLS+1:0] above_ext;
  logic [CELLS+1:0] mid_ext;
  logic [CELLS+1:0] below_ext;
  logic [CELLS-1:0] lane_alive;

  // Pad with a dead column at each edge
  assign above_ext = {1'b0, above_i, 1'b0};
  assign mid_ext   = {1'b0, mid_i, 1'b0};
  assign below_ext = {1'b0, below_i, 1'b0};

  // One lane per column, each seeing its own 3x3 window
  for (genvar k = 0; k < CELLS; k++) begin : g_lane
    lrs_cell u_cell (
      .above_i (above_ext[k+2:k]),
      .mid_i   (mid_ext[k+2:k]),
      .below_i (below_ext[k+2:k]),
      .alive_o (lane_alive[k])
    );
  end

  // Drop columns beyond the row length
  assign next_row_o = lane_alive & mask_i;

endmodule

### hdl/lrs_merge_queue.sv
module lrs_merge_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrs_pkg::push_t         push_i,
  input  lrs_pkg::res_t          first_i,
  input  lrs_pkg::res_t          second_i,
  output logic                   room_o,
  lrs_res_if.source              res_o
);
  import lrs_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;

  res_t             slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] second_ptr;
  logic [CNT_W-1:0] push_cnt;
  logic             pop;

  // Room for two results keeps a final row from ever overflowing
  assign room_o = (count_q <= CNT_W'(QDEPTH - 2));

  assign res_o.valid     = (count_q != '0);
  assign res_o.next_row  = slot_q[rd_ptr_q].next_row;
  assign res_o.frame_end = slot_q[rd_ptr_q].frame_end;
  assign pop             = res_o.valid & res_o.ready;

  // Place the second row behind the first when both arrive
  assign second_ptr = wr_ptr_q + PTR_W'(push_i.first);
  assign push_cnt   = CNT_W'(push_i.first) + CNT_W'(push_i.second);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + push_cnt - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store result payloads
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      slot_q[wr_ptr_q] <= first_i;
    end
    if (push_i.second) begin
      slot_q[second_ptr] <= second_i;
    end
  end

endmodule

### hdl/life_rule_row_stepper_unit.sv
// Throughput: one row per cycle while the queue has room; a final row yields two
// results unless it is its grid's only row, and the port drains one result
// per cycle while res_o.ready is high, from a four-entry queue, which sets the
// sustained rate. Input ready drops while fewer than two queue slots are free.
// Reset (rst_ni low, asynchronous): window and queue empty, row length 64.
module life_rule_row_stepper_unit #(
  parameter int unsigned MAX_ROW_CELLS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lrs_cfg_if.sink                  cfg_i,
  lrs_row_if.sink                  row_i,
  lrs_res_if.source                res_o
);
  import lrs_pkg::*;

  logic [LEN_BITS-1:0]      row_length_q;
  logic [MAX_ROW_CELLS-1:0] upper_q;
  logic [MAX_ROW_CELLS-1:0] middle_q;
  held_e                    held_q;
  logic [MAX_ROW_CELLS-1:0] active_mask;
  logic [MAX_ROW_CELLS-1:0] row_in;
  logic [MAX_ROW_CELLS-1:0] above_a;
  logic [MAX_ROW_CELLS-1:0] mid_b;
  logic [MAX_ROW_CELLS-1:0] row_a;
  logic [MAX_ROW_CELLS-1:0] row_b;
  logic                     room;
  logic                     accept;
  push_t                    push;
  res_t                     res_first;
  res_t                     res_second;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LEN_RESET;
    end else if (cfg_i.valid) begin
      row_length_q <= cfg_i.row_length;
    end
  end

  // Columns in use; the lane count saturates the row length
  for (genvar k = 0; k < MAX_ROW_CELLS; k++) begin : g_mask
    assign active_mask[k] = (row_length_q > LEN_BITS'(k));
  end

  assign row_in      = row_i.row_cells[MAX_ROW_CELLS-1:0] & active_mask;
  assign row_i.ready = room;
  assign accept      = row_i.valid & room;

  // Window for the middle row, and for the incoming row when it closes the grid
  assign above_a = (held_q == HELD_TWO) ? upper_q : '0;
  assign mid_b   = (held_q == HELD_NONE) ? '0 : middle_q;

  lrs_row_lanes #(.CELLS(MAX_ROW_CELLS)) u_lanes_mid (
    .above_i    (above_a),
    .mid_i      (middle_q),
    .below_i    (row_in),
    .mask_i     (active_mask),
    .next_row_o (row_a)
  );

  lrs_row_lanes #(.CELLS(MAX_ROW_CELLS)) u_lanes_last (
    .above_i    (mid_b),
    .mid_i      (row_in),
    .below_i    ('0),
    .mask_i     (active_mask),
    .next_row_o (row_b)
  );

  // Widen lane results to the port width
  always_comb begin
    res_first                                  = '0;
    res_first.next_row[MAX_ROW_CELLS-1:0]      = row_a;
    res_first.frame_end                        = 1'b0;
    res_second                                 = '0;
    res_second.next_row[MAX_ROW_CELLS-1:0]     = row_b;
    res_second.frame_end                       = 1'b1;
  end

  assign push.first  = accept & (held_q != HELD_NONE);
  assign push.second = accept & row_i.last_row;

  // Shift the row window, clear it at the end of a grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      held_q   <= HELD_NONE;
    end else if (accept) begin
      if (row_i.last_row) begin
        upper_q  <= '0;
        middle_q <= '0;
        held_q   <= HELD_NONE;
      end else if (held_q == HELD_NONE) begin
        upper_q  <= '0;
        middle_q <= row_in;
        held_q   <= HELD_ONE;
      end else begin
        upper_q  <= middle_q;
        middle_q <= row_in;
        held_q   <= HELD_TWO;
      end
    end
  end

  lrs_merge_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (res_first),
    .second_i (res_second),
    .room_o   (room),
    .res_o    (res_o)
  );

endmodule
